@@ rtl/dscp_class_edt_pacer_macros.svh @@
// Assertion macros for the pacer RTL, used by the back end.
`ifndef DSCP_CLASS_EDT_PACER_MACROS_SVH
`define DSCP_CLASS_EDT_PACER_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define DCP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define DCP_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/dcp_pkg.sv @@
// ----------------------------------------------------------------------------
// dcp_pkg
// Types and constants shared by the pacer front end, queue and back end.
// ----------------------------------------------------------------------------
package dcp_pkg;
  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [5:0]  DscpEf   = 6'd46;
  localparam logic [5:0]  DscpAf41 = 6'd34;
  localparam logic [5:0]  DscpAf31 = 6'd26;
  localparam logic [5:0]  DscpAf21 = 6'd18;
  localparam logic [63:0] NsecPerSec = 64'd1000000000;
  localparam logic [63:0] MaxDelayNs = 64'd100000000;

  localparam logic [2:0] VerdictNotIp   = 3'd0;
  localparam logic [2:0] VerdictUnpaced = 3'd1;
  localparam logic [2:0] VerdictInRate  = 3'd2;
  localparam logic [2:0] VerdictBorrow  = 3'd3;
  localparam logic [2:0] VerdictDelayed = 3'd4;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic        is_ip;
    logic [1:0]  cls;
    logic [15:0] len;
    logic [63:0] now;
  } item_t;
endpackage

@@ rtl/dcp_front.sv @@
// ----------------------------------------------------------------------------
// dcp_front
// Classifies an input packet by ethertype and DSCP and registers the item.
// ----------------------------------------------------------------------------
module dcp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        ethertype_i,
  input  logic               headers_present_i,
  input  logic [7:0]         ip_tos_i,
  input  logic [15:0]        pkt_len_i,
  input  logic [63:0]        now_ns_i,
  output logic               q_valid_o,
  input  logic               q_stall_i,
  output dcp_pkg::item_t     q_item_o
);
  logic           valid_q;
  dcp_pkg::item_t item_q, item_d;
  logic [5:0]     dscp;

  // Class decode.
  always_comb begin
    dscp = ip_tos_i[7:2];
    item_d.is_ip = (ethertype_i == dcp_pkg::EthertypeIpv4) && headers_present_i;
    item_d.len = pkt_len_i;
    item_d.now = now_ns_i;
    if (!item_d.is_ip) begin
      item_d.cls = 2'd0;
    end else if (dscp == dcp_pkg::DscpEf) begin
      item_d.cls = 2'd0;
    end else if (dscp == dcp_pkg::DscpAf41 || dscp == dcp_pkg::DscpAf31 ||
                 dscp == dcp_pkg::DscpAf21) begin
      item_d.cls = 2'd1;
    end else begin
      item_d.cls = 2'd2;
    end
  end

  assign in_stall  = valid_q && q_stall_i;
  assign q_valid_o = valid_q;
  assign q_item_o  = item_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      item_q <= item_d;
    end
  end
endmodule

@@ rtl/dcp_fifo.sv @@
// ----------------------------------------------------------------------------
// dcp_fifo
// Two-entry queue between the classifier and the pacing engine.
// ----------------------------------------------------------------------------
module dcp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  dcp_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output dcp_pkg::item_t rd_item_o
);
  dcp_pkg::item_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end
endmodule

@@ rtl/dcp_back.sv @@
// ----------------------------------------------------------------------------
// dcp_back
// Pacing engine: shared serial divider, per-class state and result register.
// ----------------------------------------------------------------------------
`include "dscp_class_edt_pacer_macros.svh"
module dcp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_stall_o,
  input  dcp_pkg::item_t q_item_i,
  input  logic [31:0]    rate_i [3],
  input  logic [31:0]    ceil_i [3],
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     traffic_class_o,
  output logic [2:0]     verdict_o,
  output logic [63:0]    depart_time_o,
  output logic [63:0]    class_packets_o,
  output logic [63:0]    class_bytes_o,
  output logic [63:0]    class_borrowed_o,
  output logic [63:0]    class_delayed_o
);
  typedef enum logic [2:0] {StIdle, StDivR, StDivC, StUpd, StOut} state_e;

  state_e         state_q;
  dcp_pkg::item_t it_q;
  logic [5:0]     bit_q;
  logic [63:0]    num_q, quo_q, rs_q;
  logic [32:0]    rem_q;
  logic [31:0]    div_q;
  logic [63:0]    rnt_q [3], cnt_q [3];
  logic [63:0]    pkt_q [3], byt_q [3], bor_q [3], dly_q [3];
  logic           ov_q;
  logic [1:0]     cls_o_q;
  logic [2:0]     ver_q, uver_q;
  logic [63:0]    dep_q, udep_q, op_q, ob_q, obr_q, od_q;

  logic [32:0] rem_sh;
  logic        ge;
  logic [63:0] now, rt, ct, cs;
  logic [1:0]  c;
  logic        out_load;

  // Restoring division step: one quotient bit per cycle.
  assign rem_sh = {rem_q[31:0], num_q[63]};
  assign ge = rem_sh >= {1'b0, div_q};

  assign c   = it_q.cls;
  assign now = it_q.now;
  assign cs  = (div_q == 32'd0) ? 64'd0 : quo_q;
  // Stale clearing of the two next-send times.
  assign rt = (rnt_q[c] != 64'd0 && now > rnt_q[c] + dcp_pkg::NsecPerSec) ? 64'd0
              : rnt_q[c];
  assign ct = (cnt_q[c] != 64'd0 && now > cnt_q[c] + dcp_pkg::NsecPerSec) ? 64'd0
              : cnt_q[c];

  // The result register loads once the previous result has left.
  assign out_load = (state_q == StOut) && (!ov_q || !out_stall);

  assign q_stall_o = (state_q != StIdle);
  assign out_valid = ov_q;
  assign traffic_class_o  = cls_o_q;
  assign verdict_o        = ver_q;
  assign depart_time_o    = dep_q;
  assign class_packets_o  = op_q;
  assign class_bytes_o    = ob_q;
  assign class_borrowed_o = obr_q;
  assign class_delayed_o  = od_q;

  // Sequencer, per-class state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rnt_q[i] <= '0; cnt_q[i] <= '0; pkt_q[i] <= '0;
        byt_q[i] <= '0; bor_q[i] <= '0; dly_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            it_q <= q_item_i;
            if (!q_item_i.is_ip || rate_i[q_item_i.cls] == 32'd0) begin
              state_q <= StOut;
            end else begin
              num_q   <= 64'(q_item_i.len) * 64'(dcp_pkg::NsecPerSec[29:0]);
              rem_q   <= '0;
              div_q   <= rate_i[q_item_i.cls];
              bit_q   <= '0;
              state_q <= StDivR;
            end
          end
        end
        StDivR, StDivC: begin
          bit_q <= bit_q + 6'd1;
          if (bit_q != 6'd63) begin
            num_q <= {num_q[62:0], ge};
            rem_q <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
          end else if (state_q == StDivR) begin
            rs_q    <= {num_q[62:0], ge};
            num_q   <= 64'(it_q.len) * 64'(dcp_pkg::NsecPerSec[29:0]);
            rem_q   <= '0;
            div_q   <= ceil_i[c];
            state_q <= StDivC;
          end else begin
            quo_q   <= {num_q[62:0], ge};
            state_q <= StUpd;
          end
        end
        StUpd: begin
          pkt_q[c] <= pkt_q[c] + 64'd1;
          byt_q[c] <= byt_q[c] + 64'(it_q.len);
          if (now >= rt) begin
            rnt_q[c] <= now + rs_q;
            cnt_q[c] <= now + cs;
            udep_q   <= '0;
            uver_q   <= dcp_pkg::VerdictInRate;
          end else if (now >= ct) begin
            rnt_q[c] <= rt;
            cnt_q[c] <= now + cs;
            bor_q[c] <= bor_q[c] + 64'd1;
            udep_q   <= '0;
            uver_q   <= dcp_pkg::VerdictBorrow;
          end else begin
            rnt_q[c] <= rt;
            if (ct > now + dcp_pkg::MaxDelayNs) begin
              udep_q   <= now + dcp_pkg::MaxDelayNs;
              cnt_q[c] <= now + dcp_pkg::MaxDelayNs + cs;
            end else begin
              udep_q   <= ct;
              cnt_q[c] <= ct + cs;
            end
            dly_q[c] <= dly_q[c] + 64'd1;
            uver_q   <= dcp_pkg::VerdictDelayed;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            cls_o_q <= it_q.cls;
            if (!it_q.is_ip) begin
              ver_q <= dcp_pkg::VerdictNotIp;
              dep_q <= '0; op_q <= '0; ob_q <= '0; obr_q <= '0; od_q <= '0;
            end else begin
              if (rate_i[c] == 32'd0) begin
                ver_q <= dcp_pkg::VerdictUnpaced;
                dep_q <= '0;
              end else begin
                ver_q <= uver_q;
                dep_q <= udep_q;
              end
              op_q <= pkt_q[c]; ob_q <= byt_q[c];
              obr_q <= bor_q[c]; od_q <= dly_q[c];
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `DCP_ASSERT_IMP(a_cls_range, clk_i, rst_ni, out_valid, traffic_class_o != 2'd3)
  `DCP_ASSERT_IMP(a_dep_zero, clk_i, rst_ni, out_valid && verdict_o != dcp_pkg::VerdictDelayed,
    depart_time_o == 64'd0)
  `DCP_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid)
endmodule

@@ rtl/dscp_class_edt_pacer.sv @@
// ----------------------------------------------------------------------------
// dscp_class_edt_pacer
// DSCP classifier with per-class rate/ceil earliest-departure-time pacing.
// ----------------------------------------------------------------------------
// A paced IPv4 packet occupies the engine for two 64-step serial
// divisions for the rate and ceil spacing on one shared radix-2 divider,
// then an update state and a result state; unpaced and non-IPv4 packets
// skip the divisions and the update. A held result stalls the engine
// until it is taken. A two-entry queue lets the classifier keep taking
// packets meanwhile.
module dscp_class_edt_pacer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] ethertype_i,
  input  logic        headers_present_i,
  input  logic [7:0]  ip_tos_i,
  input  logic [15:0] pkt_len_i,
  input  logic [63:0] now_ns_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  traffic_class_o,
  output logic [2:0]  verdict_o,
  output logic [63:0] depart_time_o,
  output logic [63:0] class_packets_o,
  output logic [63:0] class_bytes_o,
  output logic [63:0] class_borrowed_o,
  output logic [63:0] class_delayed_o
);
  logic [31:0]    rate_q [3], ceil_q [3];
  logic           f_valid, f_stall, b_valid, b_stall;
  dcp_pkg::item_t f_item, b_item;

  assign cfg_ready = 1'b1;

  // Configuration registers; indices above five are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rate_q[i] <= '0;
        ceil_q[i] <= '0;
      end
    end else if (cfg_valid && cfg_index_i <= 3'd5) begin
      if (cfg_index_i[0]) ceil_q[cfg_index_i[2:1]] <= cfg_data_i;
      else                rate_q[cfg_index_i[2:1]] <= cfg_data_i;
    end
  end

  dcp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .ethertype_i, .headers_present_i,
    .ip_tos_i, .pkt_len_i, .now_ns_i,
    .q_valid_o(f_valid), .q_stall_i(f_stall), .q_item_o(f_item)
  );

  dcp_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_item_i(f_item),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_item_o(b_item)
  );

  dcp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(b_valid), .q_stall_o(b_stall), .q_item_i(b_item),
    .rate_i(rate_q), .ceil_i(ceil_q), .out_valid, .out_stall,
    .traffic_class_o, .verdict_o, .depart_time_o, .class_packets_o,
    .class_bytes_o, .class_borrowed_o, .class_delayed_o
  );
endmodule
